// File: src/set_assoc_lru_cache_tags_unit_defines.svh
// Assertion macros for the cache tag unit.
// Used by the front end and top level.
`ifndef SET_ASSOC_LRU_CACHE_TAGS_UNIT_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_TAGS_UNIT_DEFINES_SVH
// implication checked every clock outside reset
`define SALC_ASSERT_IMP(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define SALC_ASSERT_NXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// File: src/salc_pkg.sv
// Shared types and codes for the cache tag unit.
// No dependencies.
package salc_pkg;
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_FILL  = 2'd1;
    localparam logic [1:0] OP_WBACK = 2'd2;
    localparam logic [1:0] OP_FWD   = 2'd3;

    localparam logic [1:0] CFG_WT    = 2'd0;
    localparam logic [1:0] CFG_WA    = 2'd1;
    localparam logic [1:0] CFG_WAYS  = 2'd2;

    typedef struct packed {
        logic       hit;
        logic [1:0] op;
        logic [31:0] addr;
        logic [6:0] bytes;
        logic       last;
    } t_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_EMIT,
        ST_CLR
    } t_state;
endpackage

// File: src/set_assoc_lru_cache_tags_unit.sv
// Set-associative cache tag/LRU controller: lookup front, result queue, output back.
// Results: the look state pushes the first result to the queue; a second one follows next cycle.
// Requests: start reads the RAMs, look does lookup/update, emit sends any second result; next one waits for idle.
// The receiver cannot stall; results drain from a two-entry queue one per cycle.
// Reset (sync, active low): busy for a pass over all SETS sets that clears valid/dirty, sets rank = way.
// Depends on salc_pkg, salc_front, salc_res_queue, salc_ram and the defines header.
`include "set_assoc_lru_cache_tags_unit_defines.svh"
module set_assoc_lru_cache_tags_unit #(
    parameter int SETS = 64,
    parameter int WAYS = 4,
    parameter int LINE_BYTES = 64,
    parameter int ADDR_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_req_type,
    input  logic [31:0] i_address,
    input  logic [3:0]  i_access_bytes,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [2:0]  i_cfg_data,
    output logic        o_strobe,
    output logic        o_hit,
    output logic [1:0]  o_lower_op,
    output logic [31:0] o_lower_address,
    output logic [6:0]  o_lower_bytes,
    output logic        o_last
);
    logic r_wt, r_wa;
    logic [2:0] r_ways;
    logic w_busy_f, w_push, w_qv;
    salc_pkg::t_res w_res, w_q;

    // hold config registers; the user must write them only while idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wt <= 1'b0; r_wa <= 1'b1; r_ways <= 3'd4;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                salc_pkg::CFG_WT:   r_wt   <= i_cfg_data[0];
                salc_pkg::CFG_WA:   r_wa   <= i_cfg_data[0];
                salc_pkg::CFG_WAYS: r_ways <= i_cfg_data;
                default: ;
            endcase
        end
    end

    salc_front #(.SETS(SETS), .WAYS(WAYS), .LINE_BYTES(LINE_BYTES),
                 .ADDR_WIDTH(ADDR_WIDTH)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(start),
        .i_req_type(i_req_type), .i_address(i_address),
        .i_access_bytes(i_access_bytes),
        .i_wt(r_wt), .i_wa(r_wa), .i_ways(r_ways),
        .o_busy(w_busy_f), .o_push(w_push), .o_res(w_res)
    );

    // drain one result per cycle; the receiver always takes it
    salc_res_queue u_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_data(w_res),
        .o_valid(w_qv), .o_data(w_q), .i_pop(w_qv)
    );

    assign busy            = w_busy_f;
    assign o_strobe        = w_qv;
    assign o_hit           = w_q.hit;
    assign o_lower_op      = w_q.op;
    assign o_lower_address = w_q.addr;
    assign o_lower_bytes   = w_q.bytes;
    assign o_last          = w_q.last;

    `SALC_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
    `SALC_ASSERT_IMP(a_none_zero, i_clk, i_rst_n,
        o_strobe && o_lower_op == salc_pkg::OP_NONE, o_lower_address == 32'd0)
    `SALC_ASSERT_IMP(a_push_busy, i_clk, i_rst_n, w_push, busy)
endmodule

// File: src/salc_res_queue.sv
// Two-entry result queue between the lookup front and the output back.
// Depends on salc_pkg.
module salc_res_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  salc_pkg::t_res   i_data,
    output logic             o_valid,
    output salc_pkg::t_res   o_data,
    input  logic             i_pop
);
    salc_pkg::t_res r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

// File: src/salc_front.sv
// Lookup front: register the request, compare tags, update state, queue results.
// Depends on salc_pkg, salc_ram and the defines header.
`include "set_assoc_lru_cache_tags_unit_defines.svh"
module salc_front #(
    parameter int SETS = 64,
    parameter int WAYS = 4,
    parameter int LINE_BYTES = 64,
    parameter int ADDR_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_go,
    input  logic                  i_req_type,
    input  logic [31:0]           i_address,
    input  logic [3:0]            i_access_bytes,
    input  logic                  i_wt,
    input  logic                  i_wa,
    input  logic [2:0]            i_ways,
    output logic                  o_busy,
    output logic                  o_push,
    output salc_pkg::t_res        o_res
);
    localparam int OFFW = $clog2(LINE_BYTES);
    localparam int SETW = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int SETB = $clog2(SETS);
    localparam int TAGW = (ADDR_WIDTH - OFFW - SETB > 0) ? ADDR_WIDTH - OFFW - SETB : 1;
    localparam int WAYW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int AW   = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;
    localparam int STW  = WAYS * (2 + WAYW);
    localparam logic [6:0] LB7 = 7'(LINE_BYTES);

    salc_pkg::t_state r_st, n_st;
    logic            r_wr;
    logic [31:0]     r_addr;
    logic [3:0]      r_nb;
    logic [SETW-1:0] r_set;
    logic [TAGW-1:0] r_tag;
    logic [SETW-1:0] r_clr;

    logic [TAGW-1:0] w_tag_rd [WAYS];
    logic [WAYS-1:0] w_tag_we;

    // per-set word: ranks, dirty bits, valid bits
    logic [STW-1:0]  w_st_rd, w_st_wd;
    logic            w_st_we;
    logic [SETW-1:0] w_st_wa;
    logic [SETW-1:0] w_ra;

    salc_pkg::t_res r_pend;

    logic [31:0] w_a;
    logic [ADDR_WIDTH+31:0] w_ax;
    assign w_ax = {{ADDR_WIDTH{1'b0}}, i_address};
    assign w_a  = 32'(w_ax[AW-1:0]);
    assign w_ra = (SETB > 0) ? SETW'(w_a[OFFW +: SETW]) : SETW'(0);

    genvar g;
    generate
        for (g = 0; g < WAYS; g++) begin : g_tag
            salc_ram #(.WIDTH(TAGW), .DEPTH(SETS)) u_ram (
                .i_clk (i_clk),
                .i_we  (w_tag_we[g]),
                .i_wa  (r_set),
                .i_wd  (r_tag),
                .i_ra  (w_ra),
                .o_rd  (w_tag_rd[g])
            );
        end
    endgenerate

    salc_ram #(.WIDTH(STW), .DEPTH(SETS)) u_st_ram (
        .i_clk (i_clk),
        .i_we  (w_st_we),
        .i_wa  (w_st_wa),
        .i_wd  (w_st_wd),
        .i_ra  (w_ra),
        .o_rd  (w_st_rd)
    );

    // lookup combinational
    logic [WAYS-1:0] w_act, w_match, w_inv;
    logic [WAYS-1:0] w_vb, w_db, w_nvb, w_ndb;
    logic [WAYS-1:0][WAYW-1:0] w_rk, w_nrk, w_rk0;
    logic            w_hit, w_have_inv;
    logic [WAYW-1:0] w_hway, w_iway, w_lway, w_vict, w_use;
    logic [WAYW-1:0] w_best;
    logic [3:0]      w_nact;
    logic [ADDR_WIDTH+OFFW+SETB+TAGW:0] w_vline;
    logic [31:0]     w_fill, w_wb;
    logic            w_do_wb, w_touch;
    salc_pkg::t_res  w_r0, w_r1;
    logic            w_two;

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            w_vb[w]  = w_st_rd[w];
            w_db[w]  = w_st_rd[WAYS + w];
            w_rk[w]  = w_st_rd[2*WAYS + w*WAYW +: WAYW];
            w_rk0[w] = WAYW'(w);
        end
        w_nact = (i_ways == 3'd0) ? 4'd1 : {1'b0, i_ways};
        if (32'(w_nact) > WAYS) w_nact = 4'(WAYS);
        w_hit = 1'b0; w_hway = '0; w_have_inv = 1'b0; w_iway = '0;
        w_best = '0; w_lway = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            w_act[w]   = (w < 32'(w_nact));
            w_match[w] = w_act[w] && w_vb[w] && (w_tag_rd[w] == r_tag);
            w_inv[w]   = w_act[w] && !w_vb[w];
            if (w_match[w]) begin w_hit = 1'b1; w_hway = WAYW'(w); end
            if (w_inv[w]) begin w_have_inv = 1'b1; w_iway = WAYW'(w); end
        end
        for (int w = 0; w < WAYS; w++) begin
            if (w_act[w] && w_rk[w] >= w_best) begin
                w_best = w_rk[w];
                w_lway = WAYW'(w);
            end
        end
        w_vict = w_have_inv ? w_iway : w_lway;
        w_do_wb = !w_have_inv && !i_wt && w_db[w_vict];
        w_vline = ({{(ADDR_WIDTH+OFFW+SETB+1){1'b0}}, w_tag_rd[w_vict]} << (SETB + OFFW))
                | ((ADDR_WIDTH+OFFW+SETB+TAGW+1)'(r_set) << OFFW);
        w_wb   = 32'(w_vline[AW-1:0]);
        w_fill = r_addr & ~32'(LINE_BYTES - 1);
        w_two = 1'b0;
        w_touch = 1'b1;
        w_use = w_vict;
        w_r0 = '{hit: 1'b0, op: salc_pkg::OP_NONE, addr: '0, bytes: '0, last: 1'b1};
        w_r1 = w_r0;
        if (w_hit) begin
            w_use = w_hway;
            w_r0.hit = 1'b1;
            if (r_wr && i_wt) begin
                w_r0.op = salc_pkg::OP_FWD; w_r0.addr = r_addr; w_r0.bytes = {3'b0, r_nb};
            end
        end else if (r_wr && !i_wa) begin
            w_touch = 1'b0;
            w_r0.op = salc_pkg::OP_FWD; w_r0.addr = r_addr; w_r0.bytes = {3'b0, r_nb};
        end else begin
            w_r1.op = salc_pkg::OP_FILL; w_r1.addr = w_fill; w_r1.bytes = LB7;
            if (w_do_wb) begin
                w_two = 1'b1;
                w_r0.op = salc_pkg::OP_WBACK; w_r0.addr = w_wb; w_r0.bytes = LB7;
                w_r0.last = 1'b0;
            end else if (r_wr && i_wt) begin
                w_two = 1'b1;
                w_r0 = w_r1; w_r0.last = 1'b0;
                w_r1.op = salc_pkg::OP_FWD; w_r1.addr = r_addr; w_r1.bytes = {3'b0, r_nb};
            end else begin
                w_r0 = w_r1;
            end
        end
        // updated set word: recency, dirty and valid bits
        w_nvb = w_vb;
        w_ndb = w_db;
        w_nrk = w_rk;
        if (w_touch) begin
            for (int w = 0; w < WAYS; w++)
                if (w_rk[w] < w_rk[w_use]) w_nrk[w] = w_rk[w] + WAYW'(1);
            w_nrk[w_use] = '0;
        end
        if (w_hit) begin
            if (r_wr && !i_wt) w_ndb[w_hway] = 1'b1;
        end else if (!(r_wr && !i_wa)) begin
            w_nvb[w_vict] = 1'b1;
            w_ndb[w_vict] = r_wr && !i_wt;
        end
    end

    always_comb begin
        n_st = r_st;
        w_tag_we = '0;
        w_st_we = 1'b0;
        w_st_wa = r_set;
        w_st_wd = {w_nrk, w_ndb, w_nvb};
        o_push = 1'b0;
        o_res  = w_r0;
        unique case (r_st)
            salc_pkg::ST_CLR: begin
                // clear one set per cycle after reset
                w_st_we = 1'b1;
                w_st_wa = r_clr;
                w_st_wd = {w_rk0, {WAYS{1'b0}}, {WAYS{1'b0}}};
                n_st = (r_clr == SETW'(SETS - 1)) ? salc_pkg::ST_IDLE : salc_pkg::ST_CLR;
            end
            salc_pkg::ST_IDLE: if (i_go) n_st = salc_pkg::ST_LOOK;
            salc_pkg::ST_LOOK: begin
                o_push = 1'b1;
                w_st_we = 1'b1;
                if (!w_hit && !(r_wr && !i_wa)) w_tag_we = WAYS'(1) << w_vict;
                n_st = w_two ? salc_pkg::ST_EMIT : salc_pkg::ST_IDLE;
            end
            salc_pkg::ST_EMIT: begin
                o_push = 1'b1;
                o_res  = r_pend;
                n_st   = salc_pkg::ST_IDLE;
            end
            default: n_st = salc_pkg::ST_IDLE;
        endcase
    end

    assign o_busy = (r_st != salc_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (r_st == salc_pkg::ST_IDLE && i_go) begin
            r_wr   <= ~i_req_type;
            r_addr <= w_a;
            r_nb   <= i_access_bytes;
            r_set  <= w_ra;
            r_tag  <= TAGW'(w_ax >> (OFFW + SETB));
        end
        if (r_st == salc_pkg::ST_LOOK) r_pend <= w_r1;
        if (!i_rst_n) begin
            r_st  <= salc_pkg::ST_CLR;
            r_clr <= '0;
        end else begin
            r_st <= n_st;
            if (r_st == salc_pkg::ST_CLR) r_clr <= r_clr + SETW'(1);
        end
    end

    `SALC_ASSERT_IMP(a_one_hot_we, i_clk, i_rst_n, 1'b1, $onehot0(w_tag_we))
    `SALC_ASSERT_NXT(a_emit_after_look, i_clk, i_rst_n,
        r_st == salc_pkg::ST_EMIT, r_st == salc_pkg::ST_IDLE)
    `SALC_ASSERT_IMP(a_we_on_miss, i_clk, i_rst_n, w_tag_we != '0, !w_hit)
endmodule

// File: src/salc_ram.sv
// Generic single-write, single-read RAM with registered read.
// No dependencies.
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [((DEPTH>1)?$clog2(DEPTH):1)-1:0] i_wa,
    input  logic [WIDTH-1:0]                 i_wd,
    input  logic [((DEPTH>1)?$clog2(DEPTH):1)-1:0] i_ra,
    output logic [WIDTH-1:0]                 o_rd
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_wa] <= i_wd;
        o_rd <= r_mem[i_ra];
    end
endmodule
